// ===== design/semiprime_test_macros.svh =====
// assertion macros shared by the semiprime test design
`ifndef SEMIPRIME_TEST_MACROS_SVH
`define SEMIPRIME_TEST_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SP_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");

`endif

// ===== design/sp_pkg.sv =====
// shared types and constants for the semiprime test design
package sp_pkg;

  localparam int VALUE_BITS = 16;
  localparam int IN_BITS    = 16;
  localparam int WIDE_BITS  = (VALUE_BITS > IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  typedef logic [VALUE_BITS-1:0] val_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_ISSUE,
    S_A_WAIT,
    S_B_CHECK,
    S_B_ISSUE,
    S_B_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    val_t quot;
    val_t rem;
  } div_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic result;
  } seq_stat_t;

endpackage

// ===== design/sp_div.sv =====
// restoring divider, one quotient bit per cycle
`include "semiprime_test_macros.svh"

module sp_div import sp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  val_t               rem_r;
  val_t               quo_r;
  val_t               dvs_r;
  logic [VALUE_BITS:0] rem_sh;
  logic [VALUE_BITS:0] diff;

  assign rem_sh = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= diff[VALUE_BITS] ? rem_sh[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
      quo_r <= {quo_r[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

  `SP_ASSERT_NOW(a_no_restart, req.start, !busy_r)
  `SP_ASSERT_NOW(a_rem_below_divisor, done_r && (dvs_r != '0), rem_r < dvs_r)

endmodule

// ===== design/sp_seq.sv =====
// sequencer: divisor search, then primality trial of the cofactor
`include "semiprime_test_macros.svh"

module sp_seq import sp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  val_t      value,
  input  logic      out_free,
  output seq_stat_t stat,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp
);

  state_t state_r, state_nxt;
  val_t   x_r, x_nxt;   // value under test, later the cofactor
  val_t   d_r, d_nxt;   // trial divisor
  logic   res_r, res_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (value < val_t'(4)) ? S_DONE : S_A_ISSUE;
        end
      end
      S_A_ISSUE: state_nxt = S_A_WAIT;
      S_A_WAIT: begin
        if (div_rsp.done) begin
          if (d_r > div_rsp.quot) begin
            state_nxt = S_DONE;
          end else if (div_rsp.rem == '0) begin
            state_nxt = S_B_CHECK;
          end else begin
            state_nxt = S_A_ISSUE;
          end
        end
      end
      S_B_CHECK: begin
        if (x_r < val_t'(4) || !x_r[0]) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_B_ISSUE;
        end
      end
      S_B_ISSUE: state_nxt = S_B_WAIT;
      S_B_WAIT: begin
        if (div_rsp.done) begin
          if (d_r > div_rsp.quot || div_rsp.rem == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_B_ISSUE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    x_nxt            = x_r;
    d_nxt            = d_r;
    res_nxt          = res_r;
    div_req.start    = 1'b0;
    div_req.dividend = x_r;
    div_req.divisor  = d_r;
    stat.idle        = 1'b0;
    stat.done        = 1'b0;
    stat.result      = res_r;
    unique case (state_r)
      S_IDLE: begin
        stat.idle = 1'b1;
        if (start) begin
          x_nxt   = value;
          d_nxt   = val_t'(2);
          res_nxt = 1'b0;
        end
      end
      S_A_ISSUE, S_B_ISSUE: div_req.start = 1'b1;
      S_A_WAIT: begin
        if (div_rsp.done) begin
          if (d_r <= div_rsp.quot && div_rsp.rem == '0) begin
            x_nxt = div_rsp.quot;
          end
          d_nxt = d_r + val_t'(1);
        end
      end
      S_B_CHECK: begin
        // 2 and 3 are prime, 0, 1 and other even values are not
        res_nxt = (x_r < val_t'(4)) ? (x_r >= val_t'(2)) : 1'b0;
        d_nxt   = val_t'(3);
      end
      S_B_WAIT: begin
        if (div_rsp.done) begin
          res_nxt = (d_r > div_rsp.quot);
          d_nxt   = d_r + val_t'(2);
        end
      end
      S_DONE: stat.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    d_r <= d_nxt;
  end

  `SP_ASSERT_NOW(a_divisor_at_least_two, div_req.start, d_r >= val_t'(2))
  `SP_ASSERT_NEXT(a_done_holds, stat.done && !out_free, stat.done)

endmodule

// ===== design/semiprime_test.sv =====
// top level of the semiprime test: stream handshakes around the sequencer
//
//  channel  | dir | payload                     | accepted when
//  ---------+-----+-----------------------------+---------------------------
//  in_*     | in  | tdata[15:0] value           | in_tvalid && in_tready
//  out_*    | out | tdata[0] is_semiprime       | out_tvalid && out_tready
//
//  one request runs trial divisions in the shared divider (issue, 16 quotient
//  bits, completion), one for each trial: divisors from 2 up to the smallest
//  factor or sqrt(value), then odd trials up to sqrt(cofactor) in the
//  primality check
//  in_tready is high only while the sequencer is idle
//  the result register lets a new request start while a result waits
//  rst_n is synchronous, active low, and clears all control state
`include "semiprime_test_macros.svh"

module semiprime_test import sp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata    // [0] is_semiprime, [7:1] zero
);

  logic [WIDE_BITS-1:0] in_ext;
  val_t                 value;
  logic                 in_acc;
  logic                 out_free;
  logic                 out_valid_r;
  logic                 out_data_r;
  seq_stat_t            stat;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // only the low VALUE_BITS bits of the request are tested
  assign in_ext = WIDE_BITS'(in_tdata);
  assign value  = in_ext[VALUE_BITS-1:0];

  assign in_tready = stat.idle;
  assign in_acc    = in_tvalid && in_tready;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  sp_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .value   (value),
    .out_free(out_free),
    .stat    (stat),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  sp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stat.done) begin
      out_data_r <= stat.result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r};

  `SP_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  `SP_ASSERT_NOW(a_no_accept_while_done, stat.done, !in_tready)

endmodule
